[hdl/etrm_pkg.sv]
// Shared constants and codes for the event threshold rule matcher.
`default_nettype none
package etrm_pkg;
   localparam int RULE_COUNT = 16;
   localparam int RULE_IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

   localparam int OP_W      = 2;
   localparam int INDEX_W   = 4;
   localparam int EVENT_W   = 16;
   localparam int VALUE_W   = 32;
   localparam int COMPARE_W = 3;
   localparam int ACTION_W  = 16;

   localparam logic [OP_W-1:0] OP_EVALUATE = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE    = 2'd1;
   localparam logic [OP_W-1:0] OP_DISABLE  = 2'd2;

   localparam logic [COMPARE_W-1:0] CMP_NONE = 3'd0;
   localparam logic [COMPARE_W-1:0] CMP_GT   = 3'd1;
   localparam logic [COMPARE_W-1:0] CMP_LT   = 3'd2;
   localparam logic [COMPARE_W-1:0] CMP_EQ   = 3'd3;
   localparam logic [COMPARE_W-1:0] CMP_GE   = 3'd4;
   localparam logic [COMPARE_W-1:0] CMP_LE   = 3'd5;
   localparam logic [COMPARE_W-1:0] CMP_NE   = 3'd6;
endpackage
`default_nettype wire

[hdl/etrm_channels.sv]
// Request and response channel interfaces of the rule matcher.
`default_nettype none
interface etrm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [etrm_pkg::OP_W-1:0]            operation;
   logic [etrm_pkg::INDEX_W-1:0]         rule_index;
   logic [etrm_pkg::EVENT_W-1:0]         event_id;
   logic signed [etrm_pkg::VALUE_W-1:0]  sample_value;
   logic [etrm_pkg::COMPARE_W-1:0]       compare_code;
   logic signed [etrm_pkg::VALUE_W-1:0]  threshold_value;
   logic                                 dynamic_flag;
   logic [etrm_pkg::ACTION_W-1:0]        action_id;
   logic                                 active_flag;

   modport source (output valid, operation, rule_index, event_id, sample_value,
                   compare_code, threshold_value, dynamic_flag, action_id,
                   active_flag, input ready);
   modport sink   (input valid, operation, rule_index, event_id, sample_value,
                   compare_code, threshold_value, dynamic_flag, action_id,
                   active_flag, output ready);
endinterface

interface etrm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [etrm_pkg::INDEX_W-1:0]  fired_index;
   logic [etrm_pkg::ACTION_W-1:0] fired_action;
   logic                          last_fired;

   modport source (output valid, fired_index, fired_action, last_fired, input ready);
   modport sink   (input valid, fired_index, fired_action, last_fired, output ready);
endinterface
`default_nettype wire

[hdl/etrm_compare.sv]
// Shared signed threshold comparator used by the rule scan.
`default_nettype none
module etrm_compare (
   input  wire logic [etrm_pkg::COMPARE_W-1:0]      compare_code,
   input  wire logic signed [etrm_pkg::VALUE_W-1:0] sample,
   input  wire logic signed [etrm_pkg::VALUE_W-1:0] threshold,
   output logic                                     hit
);
   always_comb begin
      unique case (compare_code)
         etrm_pkg::CMP_GT: hit = sample >  threshold;
         etrm_pkg::CMP_LT: hit = sample <  threshold;
         etrm_pkg::CMP_EQ: hit = sample == threshold;
         etrm_pkg::CMP_GE: hit = sample >= threshold;
         etrm_pkg::CMP_LE: hit = sample <= threshold;
         etrm_pkg::CMP_NE: hit = sample != threshold;
         default:          hit = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

[hdl/event_threshold_rule_matcher_top.sv]
// Event threshold rule matcher: rule table, scan sequencer and result register.
//
// Requests arrive on req_ch (valid/ready). A write request loads one rule
// entry and a disable request clears an entry's active mark; each gives no
// response, so they can follow back to back. An evaluate request starts a
// scan of the rule table, one entry per cycle unless the scan halts, through
// a single shared comparator, followed by a flush state for the final result.
// req_ch is not ready during the scan and the flush, so no new request is
// accepted until the evaluation is finished. Each rule that fires yields one
// response on rsp_ch carrying its index and action, with last_fired set on
// the final one; an event that fires nothing gives no response. Results leave
// through one output register: a fired rule waits in a holding slot until the
// next hit or the end of the scan decides its last_fired mark, and the scan
// halts while a new hit finds the slot occupied, the output register full
// and the receiver stalling. Reset is synchronous: it clears every entry's
// used and active marks, the sequencer and the output register; no clearing
// pass is needed.
`default_nettype none
module event_threshold_rule_matcher_top (
   input wire logic  clock,
   input wire logic  reset,
   etrm_req_if.sink  req_ch,
   etrm_rsp_if.source rsp_ch
);
   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_type;

   localparam int RC  = etrm_pkg::RULE_COUNT;
   localparam int IW  = etrm_pkg::RULE_IDX_W;

   state_type                           state_ff, state_in;
   logic [RC-1:0]                       used_ff, used_in;
   logic [RC-1:0]                       active_ff, active_in;
   logic [etrm_pkg::EVENT_W-1:0]        entry_event_ff [RC];
   logic [etrm_pkg::COMPARE_W-1:0]      entry_compare_ff [RC];
   logic signed [etrm_pkg::VALUE_W-1:0] entry_threshold_ff [RC];
   logic [RC-1:0]                       entry_dynamic_ff;
   logic [etrm_pkg::ACTION_W-1:0]       entry_action_ff [RC];

   logic [IW-1:0]                       scan_idx_ff, scan_idx_in;
   logic [etrm_pkg::EVENT_W-1:0]        ev_ff, ev_in;
   logic signed [etrm_pkg::VALUE_W-1:0] sample_ff, sample_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic [etrm_pkg::INDEX_W-1:0]        pend_index_ff, pend_index_in;
   logic [etrm_pkg::ACTION_W-1:0]       pend_action_ff, pend_action_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [etrm_pkg::INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [etrm_pkg::ACTION_W-1:0]       rsp_action_ff, rsp_action_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                wr_en;
   logic [IW-1:0]                       wr_idx;
   logic                                idx_ok;
   logic signed [etrm_pkg::VALUE_W-1:0] cur_threshold;
   logic                                cmp_hit;
   logic                                match;
   logic                                hit;
   logic                                out_free;
   logic                                scan_end;

   assign wr_idx   = IW'(req_ch.rule_index);
   assign idx_ok   = 32'(req_ch.rule_index) < RC;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign scan_end = scan_idx_ff == IW'(RC - 1);

   assign cur_threshold = entry_dynamic_ff[scan_idx_ff] ? '0
                                                         : entry_threshold_ff[scan_idx_ff];
   assign match = used_ff[scan_idx_ff] && active_ff[scan_idx_ff]
                  && (entry_event_ff[scan_idx_ff] == ev_ff);
   assign hit   = match && cmp_hit;

   etrm_compare u_compare (
      .compare_code (entry_compare_ff[scan_idx_ff]),
      .sample       (sample_ff),
      .threshold    (cur_threshold),
      .hit          (cmp_hit)
   );

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      active_in      = active_ff;
      scan_idx_in    = scan_idx_ff;
      ev_in          = ev_ff;
      sample_in      = sample_ff;
      pend_valid_in  = pend_valid_ff;
      pend_index_in  = pend_index_ff;
      pend_action_in = pend_action_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.operation)
                  etrm_pkg::OP_EVALUATE: begin
                     ev_in         = req_ch.event_id;
                     sample_in     = req_ch.sample_value;
                     scan_idx_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  etrm_pkg::OP_WRITE: begin
                     if (idx_ok) begin
                        wr_en             = 1'b1;
                        used_in[wr_idx]   = 1'b1;
                        active_in[wr_idx] = req_ch.active_flag;
                     end
                  end
                  etrm_pkg::OP_DISABLE: begin
                     if (idx_ok) begin
                        active_in[wr_idx] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_index_in  = pend_index_ff;
                     rsp_action_in = pend_action_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_index_in  = etrm_pkg::INDEX_W'(scan_idx_ff);
                  pend_action_in = entry_action_ff[scan_idx_ff];
               end
               if (scan_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = pend_index_ff;
               rsp_action_in = pend_action_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      ev_ff          <= ev_in;
      sample_ff      <= sample_in;
      pend_index_ff  <= pend_index_in;
      pend_action_ff <= pend_action_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_last_ff    <= rsp_last_in;
      if (wr_en) begin
         entry_event_ff[wr_idx]     <= req_ch.event_id;
         entry_compare_ff[wr_idx]   <= req_ch.compare_code;
         entry_threshold_ff[wr_idx] <= req_ch.threshold_value;
         entry_dynamic_ff[wr_idx]   <= req_ch.dynamic_flag;
         entry_action_ff[wr_idx]    <= req_ch.action_id;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ch.ready        = state_ff == ST_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.fired_index  = rsp_index_ff;
   assign rsp_ch.fired_action = rsp_action_ff;
   assign rsp_ch.last_fired   = rsp_last_ff;
endmodule
`default_nettype wire
